// ===== rtl/pcxd_pkg.sv =====
// Shared types and constants for the PCX run-length image decoder.
// Used by the controller, datapath, output stage and top level; no dependencies.
package pcxd_pkg;

  localparam int MAX_LINE_BYTES_DEF = 1024;
  localparam int DIM_W              = 11;   // bytes_per_line and image_width registers
  localparam int HEIGHT_W           = 16;
  localparam int DIM_MAX            = 2047; // largest value an 11-bit dimension can hold
  localparam int BYTE_W             = 8;
  localparam int COUNT_W            = 6;
  localparam int PIX_W              = 24;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;
  localparam int USER_W             = 2;
  localparam logic [BYTE_W-1:0] RUN_MARK = 8'd192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_BPL    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic              place;       // place one decoded byte this cycle
    logic              place_last;  // last placement caused by the current input word
    logic [BYTE_W-1:0] data;
    logic              derive;      // load clamped bytes_per_line and height, start position recompute
    logic              div_step;    // one step of the position recompute
  } cmd_t;

  // datapath to output stage, one placed byte after the line store read
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             run_end;
    logic [PIX_W-1:0] value;
    logic             eor;
    logic             eoi;
  } pix_t;

  // usable line length, capped by the store size and the register width
  function automatic int bpl_limit(int max_bytes);
    return (max_bytes < DIM_MAX) ? max_bytes : DIM_MAX;
  endfunction

  // width of the position within a scanline across three planes
  function automatic int lp_width(int max_bytes);
    return $clog2(3 * bpl_limit(max_bytes));
  endfunction

endpackage

// ===== rtl/pcxd_ctrl.sv =====
// Controller for the PCX decoder: run-marker parsing, run expansion and the
// position recompute after a register write. Depends on pcxd_pkg.
module pcxd_ctrl #(
  parameter int MAX_LINE_BYTES = pcxd_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pcxd_pkg::BYTE_W-1:0] in_data,
  input  logic                       cfg_wr_en,
  input  logic                       adv,
  input  logic                       image_done,
  output pcxd_pkg::cmd_t             cmd
);
  import pcxd_pkg::*;

  localparam int LP_W  = lp_width(MAX_LINE_BYTES);
  localparam int CNT_W = $clog2(LP_W + 1);
  localparam logic [CNT_W-1:0] CALC_LAST = CNT_W'(LP_W);

  typedef enum logic [1:0] {IDLE, EXPAND, CALC} state_t;

  state_t             state;
  logic               run_pending;
  logic [COUNT_W-1:0] run_length;
  logic [COUNT_W-1:0] remaining;
  logic [BYTE_W-1:0]  byte_q;
  logic [CNT_W-1:0]   calc_cnt;

  logic in_fire;
  logic is_mark;

  assign in_ready = (state == IDLE) && adv;
  assign in_fire  = in_valid && in_ready;
  assign is_mark  = in_data >= RUN_MARK;

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        cmd.data = in_data;
        if (in_fire && !image_done) begin
          if (run_pending) begin
            cmd.place      = run_length != '0;
            cmd.place_last = run_length == COUNT_W'(1);
          end else if (!is_mark) begin
            cmd.place      = 1'b1;
            cmd.place_last = 1'b1;
          end
        end
      end
      EXPAND: begin
        cmd.data       = byte_q;
        cmd.place      = adv && !image_done;
        cmd.place_last = remaining == COUNT_W'(1);
      end
      CALC: begin
        cmd.derive   = calc_cnt == '0;
        cmd.div_step = calc_cnt != '0;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      run_pending <= 1'b0;
      run_length  <= '0;
      remaining   <= '0;
      calc_cnt    <= '0;
    end else if (cfg_wr_en) begin
      state    <= CALC;
      calc_cnt <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_fire && !image_done) begin
            if (run_pending) begin
              run_pending <= 1'b0;
              remaining   <= run_length - COUNT_W'(1);
              byte_q      <= in_data;
              if (run_length > COUNT_W'(1)) begin
                state <= EXPAND;
              end
            end else if (is_mark) begin
              run_pending <= 1'b1;
              run_length  <= in_data[COUNT_W-1:0];
            end
          end
        end
        EXPAND: begin
          if (image_done) begin
            state <= IDLE;
          end else if (adv) begin
            remaining <= remaining - COUNT_W'(1);
            if (remaining == COUNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        CALC: begin
          if (calc_cnt == CALC_LAST) begin
            state <= IDLE;
          end else begin
            calc_cnt <= calc_cnt + CNT_W'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pcxd_dp.sv =====
// Datapath for the PCX decoder: registers, scanline position, red and green
// line stores, position divider and the store read stage. Depends on pcxd_pkg.
module pcxd_dp #(
  parameter int MAX_LINE_BYTES = pcxd_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pcxd_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [pcxd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  pcxd_pkg::cmd_t                 cmd,
  input  logic                           adv,
  output logic                           image_done,
  output pcxd_pkg::pix_t                 p1
);
  import pcxd_pkg::*;

  localparam int BPL_MAX = bpl_limit(MAX_LINE_BYTES);
  localparam int BPL_W   = $clog2(BPL_MAX + 1);
  localparam int ADDR_W  = $clog2(BPL_MAX);
  localparam int LP_W    = lp_width(MAX_LINE_BYTES);
  localparam int LT_W    = LP_W + 1;

  // registers as written
  logic                rgb_mode;
  logic [DIM_W-1:0]    bpl_cfg;
  logic [DIM_W-1:0]    width_cfg;
  logic [HEIGHT_W-1:0] height_cfg;

  // derived geometry
  logic [BPL_W-1:0]    bpl_eff;
  logic [BPL_W-1:0]    width_m1;
  logic [HEIGHT_W-1:0] height_m1;
  logic [LT_W-1:0]     line_total;

  // position; plane and col also serve as quotient and remainder of the divider
  logic [LP_W-1:0]     lp;
  logic [LP_W-1:0]     plane;
  logic [BPL_W-1:0]    col;
  logic [HEIGHT_W-1:0] row;

  logic [BYTE_W-1:0] red_mem   [BPL_MAX];
  logic [BYTE_W-1:0] green_mem [BPL_MAX];
  logic [BYTE_W-1:0] red_q;
  logic [BYTE_W-1:0] green_q;

  logic              p1_v;
  logic              p1_emit;
  logic              p1_end;
  logic              p1_rgb;
  logic [BYTE_W-1:0] p1_byte;
  logic              p1_eor;
  logic              p1_eoi;

  logic [1:0]       planes_m1;
  logic [1:0]       plane_eff;
  logic             col_vis;
  logic             emit;
  logic             wr_red;
  logic             wr_green;
  logic [LT_W-1:0]  lp_inc;
  logic             line_end;
  logic             last_row;
  logic             eor;
  logic [BPL_W-1:0] col_inc;
  logic [ADDR_W-1:0] addr;
  logic [BPL_W:0]   trial;
  logic [BPL_W-1:0] bpl_eff_next;
  logic [DIM_W-1:0] width_eff;
  logic [LT_W-1:0]  bpl_ext;

  always_comb begin
    planes_m1 = rgb_mode ? 2'd2 : 2'd0;
    plane_eff = (plane > LP_W'(planes_m1)) ? planes_m1 : plane[1:0];
    col_vis   = col <= width_m1;
    emit      = rgb_mode ? (plane_eff == 2'd2) && col_vis : col_vis;
    wr_red    = rgb_mode && (plane_eff == 2'd0);
    wr_green  = rgb_mode && (plane_eff == 2'd1);
    lp_inc    = LT_W'(lp) + LT_W'(1);
    line_end  = lp_inc >= line_total;
    last_row  = row >= height_m1;
    eor       = col == width_m1;
    col_inc   = col + BPL_W'(1);
    addr      = col[ADDR_W-1:0];
    trial     = {col, plane[LP_W-1]} - {1'b0, bpl_eff};
  end

  // clamp bytes_per_line to the store size and image_width to bytes_per_line, zero reads as one
  always_comb begin
    if (bpl_cfg == '0) begin
      bpl_eff_next = BPL_W'(1);
    end else if (bpl_cfg > DIM_W'(BPL_MAX)) begin
      bpl_eff_next = BPL_W'(BPL_MAX);
    end else begin
      bpl_eff_next = BPL_W'(bpl_cfg);
    end
    width_eff = (width_cfg == '0) ? DIM_W'(1) : width_cfg;
    if (width_eff > DIM_W'(bpl_eff)) begin
      width_eff = DIM_W'(bpl_eff);
    end
    bpl_ext = LT_W'(bpl_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_mode   <= 1'b0;
      bpl_cfg    <= DIM_W'(1);
      width_cfg  <= DIM_W'(1);
      height_cfg <= HEIGHT_W'(1);
      bpl_eff    <= BPL_W'(1);
      width_m1   <= '0;
      height_m1  <= '0;
      line_total <= LT_W'(1);
      lp         <= '0;
      plane      <= '0;
      col        <= '0;
      row        <= '0;
      image_done <= 1'b0;
      p1_v       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_wr_index))
          CFG_MODE:   rgb_mode   <= cfg_wr_data[0];
          CFG_BPL:    bpl_cfg    <= cfg_wr_data[DIM_W-1:0];
          CFG_WIDTH:  width_cfg  <= cfg_wr_data[DIM_W-1:0];
          CFG_HEIGHT: height_cfg <= cfg_wr_data[HEIGHT_W-1:0];
          default:    rgb_mode   <= rgb_mode;
        endcase
      end

      if (cmd.derive) begin
        bpl_eff   <= bpl_eff_next;
        height_m1 <= (height_cfg == '0) ? '0 : height_cfg - HEIGHT_W'(1);
        plane     <= lp;
        col       <= '0;
      end else if (cmd.div_step) begin
        // restoring division of lp by bpl_eff, one quotient bit a step
        width_m1   <= BPL_W'(width_eff - DIM_W'(1));
        line_total <= rgb_mode ? (bpl_ext + {bpl_ext[LT_W-2:0], 1'b0}) : bpl_ext;
        if (!trial[BPL_W]) begin
          col <= trial[BPL_W-1:0];
        end else begin
          col <= {col[BPL_W-2:0], plane[LP_W-1]};
        end
        plane <= {plane[LP_W-2:0], ~trial[BPL_W]};
      end else if (cmd.place) begin
        if (line_end) begin
          lp    <= '0;
          plane <= '0;
          col   <= '0;
          row   <= row + HEIGHT_W'(1);
          if (last_row) begin
            image_done <= 1'b1;
          end
        end else begin
          lp <= lp_inc[LP_W-1:0];
          if (col_inc == bpl_eff) begin
            col   <= '0;
            plane <= plane + LP_W'(1);
          end else begin
            col <= col_inc;
          end
        end
      end

      if (adv) begin
        p1_v <= cmd.place;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_emit <= emit;
      p1_end  <= cmd.place_last || (line_end && last_row);
      p1_rgb  <= rgb_mode;
      p1_byte <= cmd.data;
      p1_eor  <= eor;
      p1_eoi  <= eor && last_row;
    end
  end

  // line stores
  always_ff @(posedge clk) begin
    if (cmd.place && wr_red) begin
      red_mem[addr] <= cmd.data;
    end
    if (cmd.place && wr_green) begin
      green_mem[addr] <= cmd.data;
    end
    if (adv) begin
      red_q   <= red_mem[addr];
      green_q <= green_mem[addr];
    end
  end

  always_comb begin
    p1.valid   = p1_v;
    p1.emit    = p1_emit;
    p1.run_end = p1_end;
    p1.value   = p1_rgb ? {red_q, green_q, p1_byte} : {{(PIX_W-BYTE_W){1'b0}}, p1_byte};
    p1.eor     = p1_eor;
    p1.eoi     = p1_eoi;
  end

endmodule

// ===== rtl/pcxd_out.sv =====
// Output stage for the PCX decoder: holds one pixel until it is known whether
// it ends its input word's run, then drives the output register. Depends on pcxd_pkg.
module pcxd_out (
  input  logic                         clk,
  input  logic                         rst,
  input  pcxd_pkg::pix_t               p1,
  output logic                         adv,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [pcxd_pkg::PIX_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic [pcxd_pkg::USER_W-1:0]  m_axis_tuser
);
  import pcxd_pkg::*;

  logic             h_v;
  logic             h_end;
  logic [PIX_W-1:0] h_value;
  logic             h_eor;
  logic             h_eoi;

  logic push;
  logic push_last;

  assign adv = !m_axis_tvalid || m_axis_tready;

  // the held pixel leaves at once if it ends its run, else once a later placement shows whether it was the last
  always_comb begin
    push      = h_v && (h_end || (p1.valid && (p1.emit || p1.run_end)));
    push_last = h_end || !p1.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= push;
      if (p1.valid && p1.emit) begin
        h_v <= 1'b1;
      end else if (push) begin
        h_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (p1.valid && p1.emit) begin
        h_end   <= p1.run_end;
        h_value <= p1.value;
        h_eor   <= p1.eor;
        h_eoi   <= p1.eoi;
      end
      if (push) begin
        m_axis_tdata <= h_value;
        m_axis_tlast <= push_last;
        m_axis_tuser <= {h_eoi, h_eor};
      end
    end
  end

endmodule

// ===== rtl/pcx_rle_image_decoder_unit.sv =====
// PCX run-length decoder, top level. Takes one encoded byte per word after the
// 128-byte file header and emits pixels: 8-bit palette indices or packed RGB.
// A literal byte or a run marker does not hold the input; a run's data byte holds
// the input until the run is expanded, since the datapath places one decoded
// byte per cycle, while the output does not stall, through the single-port line
// stores. A pixel passes the p1 register, the hold register and the output
// register on its way out; a pixel followed in the same run by bytes that make no
// pixel (padding, red or green plane) waits for the next pixel or the end of the
// run, since only then is its last_of_run flag known. Each register write starts a
// position recompute (a bit-serial divide of the line position by bytes_per_line)
// that holds s_axis_tready low while it runs.
// Bytes after the last row are taken and dropped.
module pcx_rle_image_decoder_unit #(
  parameter int MAX_LINE_BYTES = pcxd_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pcxd_pkg::BYTE_W-1:0]     s_axis_tdata,  // encoded_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pcxd_pkg::PIX_W-1:0]      m_axis_tdata,  // pixel_value
  output logic                           m_axis_tlast,  // last_of_run
  output logic [pcxd_pkg::USER_W-1:0]     m_axis_tuser,  // end_of_row, end_of_image
  input  logic                           cfg_wr_en,
  input  logic [pcxd_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [pcxd_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import pcxd_pkg::*;

  cmd_t cmd;
  pix_t p1;
  logic adv;
  logic image_done;

  pcxd_ctrl #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .adv        (adv),
    .image_done (image_done),
    .cmd        (cmd)
  );

  pcxd_dp #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .adv          (adv),
    .image_done   (image_done),
    .p1           (p1)
  );

  pcxd_out u_out (
    .clk           (clk),
    .rst           (rst),
    .p1            (p1),
    .adv           (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the PCX run-length image decoder unit.
// Needs pcxd_pkg and pcx_rle_image_decoder_unit; predicts pixels per accepted
// encoded word and checks every output word in order, under random stalls.
`timescale 1ns / 100ps

module tb;
  import pcxd_pkg::*;

  localparam int LINE_MAX  = MAX_LINE_BYTES_DEF;
  localparam int QUIET_CYC = 100;     // longer than a 63-byte run plus pixel latency
  localparam int HOLD_CYC  = 400;
  localparam int DRAIN_MAX = 20000;
  localparam int CYC_LIMIT = 800000;
  localparam int CALM_LO   = 1200;
  localparam int CALM_HI   = 3600;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             run_last;
    logic             row_end;
    logic             img_end;
  } pixel_t;

  typedef struct packed {
    logic              is_cfg;
    cfg_idx_t          idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic [BYTE_W-1:0] data;
  } feed_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata = '0;   // encoded_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;        // pixel_value
  logic                  m_axis_tlast;        // last_of_run
  logic [USER_W-1:0]     m_axis_tuser;        // end_of_row, end_of_image
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  pcx_rle_image_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data)
  );

  feed_t  feed_q[$];
  pixel_t pix_exp[$];
  int     mismatches = 0;
  int     pix_seen = 0;
  int     cyc = 0;
  int     quiet = 0;
  logic   feed_busy = 1'b1;
  logic   calm;

  assign calm = (cyc >= CALM_LO) && (cyc < CALM_HI);

  // decoder shadow: configuration and scan state
  logic              p_mode;
  logic [DIM_W-1:0]  p_bpl;
  logic [DIM_W-1:0]  p_width;
  logic [HEIGHT_W-1:0] p_height;
  logic              run_pend;
  logic [COUNT_W-1:0] run_cnt;
  int                line_pos;
  logic [HEIGHT_W-1:0] row_idx;
  logic              img_done;
  logic [BYTE_W-1:0] red_line [0:LINE_MAX-1];
  logic [BYTE_W-1:0] green_line [0:LINE_MAX-1];

  // stimulus-side position tracking, used to line phases up with scanlines
  int g_lp = 0;
  int g_row = 0;
  int g_span = 1;
  int g_items = 0;

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 30) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // expand one encoded word into the pixels it should produce
  function automatic void decode_word(logic [BYTE_W-1:0] b);
    int     count, bpl, width, height, planes, plane, col;
    pixel_t px, held;
    bit     have, emit;
    have = 1'b0;
    held = '0;
    if (img_done) return;
    if (run_pend) begin
      run_pend = 1'b0;
      count = run_cnt;
    end else if (b >= RUN_MARK) begin
      run_pend = 1'b1;
      run_cnt = b[COUNT_W-1:0];
      return;
    end else begin
      count = 1;
    end
    bpl = (p_bpl == 0) ? 1 : (p_bpl > LINE_MAX) ? LINE_MAX : p_bpl;
    width = (p_width == 0) ? 1 : p_width;
    if (width > bpl) width = bpl;
    height = (p_height == 0) ? 1 : p_height;
    planes = p_mode ? 3 : 1;
    for (int i = 0; i < count && !img_done; i++) begin
      plane = line_pos / bpl;
      col = line_pos % bpl;
      if (plane >= planes) plane = planes - 1;
      emit = 1'b0;
      px = '0;
      if (planes == 1) begin
        if (col < width) begin
          emit = 1'b1;
          px.value = {16'h0, b};
        end
      end else if (plane == 0) begin
        red_line[col] = b;
      end else if (plane == 1) begin
        green_line[col] = b;
      end else if (col < width) begin
        emit = 1'b1;
        px.value = {red_line[col], green_line[col], b};
      end
      if (emit) begin
        px.row_end = (col == width - 1);
        px.img_end = px.row_end && (row_idx >= height - 1);
        if (have) pix_exp.push_back(held);
        held = px;
        have = 1'b1;
      end
      if (line_pos + 1 >= planes * bpl) begin
        line_pos = 0;
        if (row_idx >= height - 1) img_done = 1'b1;
        row_idx = row_idx + 1'b1;
      end else begin
        line_pos++;
      end
    end
    if (have) begin
      held.run_last = 1'b1;
      pix_exp.push_back(held);
    end
  endfunction

  // ---------------- stimulus building ----------------

  task automatic push_cfg(cfg_idx_t idx, int val);
    feed_t e;
    e = '0;
    e.is_cfg = 1'b1;
    e.idx = idx;
    e.wdata = val[CFG_DATA_W-1:0];
    feed_q.push_back(e);
  endtask

  task automatic push_raw(logic [BYTE_W-1:0] b);
    feed_t e;
    e = '0;
    e.data = b;
    feed_q.push_back(e);
  endtask

  task automatic gen_advance(int n);
    repeat (n) begin
      if (g_lp + 1 >= g_span) begin
        g_lp = 0;
        g_row++;
      end else begin
        g_lp++;
      end
    end
  endtask

  function automatic int to_line_end();
    return (g_lp >= g_span) ? 1 : g_span - g_lp;
  endfunction

  task automatic push_lit(logic [BYTE_W-1:0] b);
    push_raw(b);
    g_items++;
    gen_advance(1);
  endtask

  task automatic push_run(int cnt, logic [BYTE_W-1:0] b);
    push_raw(RUN_MARK | cnt[COUNT_W-1:0]);
    push_raw(b);
    g_items += 2;
    gen_advance(cnt);
  endtask

  task automatic gen_cfg(int mode, int bpl, int width, int height);
    int b;
    b = (bpl == 0) ? 1 : (bpl > LINE_MAX) ? LINE_MAX : bpl;
    g_span = (mode != 0) ? 3 * b : b;
    push_cfg(CFG_MODE, mode);
    push_cfg(CFG_BPL, bpl);
    push_cfg(CFG_WIDTH, width);
    push_cfg(CFG_HEIGHT, height);
  endtask

  // encode exactly n decoded bytes as a random mix of literals and runs
  task automatic fill(int n, bit long_runs);
    int r, c, cap;
    while (n > 0) begin
      r = $urandom_range(0, 99);
      cap = (n < 63) ? n : 63;
      if (r < 6) begin
        push_run(0, BYTE_W'($urandom_range(0, 255)));
      end else if (r < (long_runs ? 10 : 45)) begin
        push_lit(BYTE_W'($urandom_range(0, RUN_MARK - 1)));
        n--;
      end else begin
        c = (long_runs || r >= 90) ? cap : $urandom_range(1, cap);
        push_run(c, BYTE_W'($urandom_range(0, 255)));
        n -= c;
      end
    end
  endtask

  task automatic gen_lines(int k, bit long_runs);
    fill(to_line_end() + (k - 1) * g_span, long_runs);
  endtask

  // ---------------- clock, limit ----------------

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- input side ----------------

  always @(posedge clk) begin : feed_drive
    feed_t            nx;
    logic             v, we;
    logic [BYTE_W-1:0] d;
    logic [CFG_IDX_W-1:0] wi;
    logic [CFG_DATA_W-1:0] wd;
    v = s_axis_tvalid;
    d = s_axis_tdata;
    we = 1'b0;
    wi = cfg_wr_index;
    wd = cfg_wr_data;
    if (!rst && !(s_axis_tvalid && !s_axis_tready)) begin
      v = 1'b0;
      if (feed_q.size() != 0) begin
        nx = feed_q[0];
        if (nx.is_cfg) begin
          // register writes only once the decoder has gone quiet
          if (quiet >= QUIET_CYC) begin
            nx = feed_q.pop_front();
            we = 1'b1;
            wi = nx.idx;
            wd = nx.wdata;
          end
        end else if (calm || $urandom_range(0, 99) >= 8) begin
          nx = feed_q.pop_front();
          v = 1'b1;
          d = nx.data;
        end
      end
    end
    s_axis_tvalid <= v;
    s_axis_tdata <= d;
    cfg_wr_en <= we;
    cfg_wr_index <= wi;
    cfg_wr_data <= wd;
    if (!rst) feed_busy <= (feed_q.size() != 0) || v;
  end

  // ---------------- output side ----------------

  int rx_cnt = 0;
  int hold_left = 0;
  int next_hold = 100;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) rx_cnt++;
      // long back-pressure so the decoder backs up into its input
      if (hold_left == 0 && rx_cnt >= next_hold) begin
        hold_left = HOLD_CYC;
        next_hold = rx_cnt + 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // ---------------- prediction and checking ----------------

  always @(posedge clk) begin : watch
    pixel_t want;
    logic   out_acc;
    out_acc = m_axis_tvalid && m_axis_tready;
    if (rst) begin
      p_mode = 1'b0;
      p_bpl = DIM_W'(1);
      p_width = DIM_W'(1);
      p_height = HEIGHT_W'(1);
      run_pend = 1'b0;
      run_cnt = '0;
      line_pos = 0;
      row_idx = '0;
      img_done = 1'b0;
      quiet <= 0;
    end else begin
      if (out_acc) begin
        if (pix_exp.size() == 0) begin
          report($sformatf("pixel %0d unexpected, data %06h", pix_seen, m_axis_tdata));
        end else begin
          want = pix_exp.pop_front();
          if (m_axis_tdata !== want.value)
            report($sformatf("pixel %0d value %06h, want %06h",
                             pix_seen, m_axis_tdata, want.value));
          if (m_axis_tlast !== want.run_last)
            report($sformatf("pixel %0d last_of_run %b, want %b",
                             pix_seen, m_axis_tlast, want.run_last));
          if (m_axis_tuser[0] !== want.row_end)
            report($sformatf("pixel %0d end_of_row %b, want %b",
                             pix_seen, m_axis_tuser[0], want.row_end));
          if (m_axis_tuser[1] !== want.img_end)
            report($sformatf("pixel %0d end_of_image %b, want %b",
                             pix_seen, m_axis_tuser[1], want.img_end));
        end
        pix_seen++;
      end
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_wr_index))
          CFG_MODE:   p_mode = cfg_wr_data[0];
          CFG_BPL:    p_bpl = cfg_wr_data[DIM_W-1:0];
          CFG_WIDTH:  p_width = cfg_wr_data[DIM_W-1:0];
          CFG_HEIGHT: p_height = cfg_wr_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_word(s_axis_tdata);
      if (s_axis_tvalid || out_acc || pix_exp.size() != 0) quiet <= 0;
      else if (quiet < QUIET_CYC) quiet <= quiet + 1;
    end
  end

  // ---------------- test sequence ----------------

  initial begin : run_test
    int mode, bpl, width, height, h_eff, rows_left, total, tail, drain;

    // index mode with padding: literal extremes, zero run, single and full runs
    gen_cfg(0, 8, 5, 65535);
    push_lit(8'h00);
    push_lit(8'hBF);
    push_run(0, 8'h37);
    push_run(1, 8'hFF);
    push_run(63, 8'hA5);
    push_lit(8'h55);
    push_lit(8'hAA);
    push_run(2, RUN_MARK);
    push_lit(8'h01);
    push_lit(8'h80);
    fill(to_line_end(), 1'b0);
    fill(5, 1'b0);

    // shrink the line while mid-line: the position is past the new length
    gen_cfg(0, 3, 0, 65535);
    gen_lines(3, 1'b0);

    // full-size rgb line writes every line store entry
    gen_cfg(1, LINE_MAX, LINE_MAX, 65535);
    gen_lines(1, 1'b1);

    // oversized dimensions, then cut short mid-line again
    gen_cfg(0, 2047, 2047, 65535);
    fill(40, 1'b0);
    gen_cfg(0, 16, 9, 65535);
    gen_lines(2, 1'b0);
    gen_cfg(1, 4, 9, 65535);
    gen_lines(2, 1'b0);
    gen_cfg(1, 0, 0, 65535);
    gen_lines(3, 1'b0);

    while (g_items < 250) begin
      mode = $urandom_range(0, 1);
      bpl = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      width = $urandom_range(0, bpl + 2);
      height = $urandom_range(60000, 65535);
      gen_cfg(mode, bpl, width, height);
      gen_lines($urandom_range(1, 4), $urandom_range(0, 3) == 0);
    end

    // last image rows, a run that spills past the end, then ignored bytes
    mode = $urandom_range(0, 1);
    bpl = $urandom_range(2, 10);
    width = $urandom_range(1, bpl);
    height = $urandom_range(0, 1) ? 0 : g_row + 2;
    gen_cfg(mode, bpl, width, height);
    h_eff = (height == 0) ? 1 : height;
    rows_left = (h_eff > g_row) ? h_eff - g_row : 1;
    total = to_line_end() + (rows_left - 1) * g_span;
    tail = $urandom_range(1, (total < 20) ? total : 20);
    fill(total - tail, 1'b0);
    push_run((tail + 30 > 63) ? 63 : tail + $urandom_range(1, 30),
             BYTE_W'($urandom_range(0, 255)));
    repeat (12) push_raw(BYTE_W'($urandom_range(0, 255)));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (feed_busy) @(posedge clk);
    drain = 0;
    while (quiet < QUIET_CYC && drain < DRAIN_MAX) begin
      @(posedge clk);
      drain++;
    end
    if (pix_exp.size() != 0)
      report($sformatf("%0d pixels never came out", pix_exp.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
